// File: rtl/core/bounded_topk_nearest_heap_top_assert.svh
`ifndef BOUNDED_TOPK_NEAREST_HEAP_TOP_ASSERT_SVH
`define BOUNDED_TOPK_NEAREST_HEAP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BTKH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btkh check failed");

// next-cycle implication, checked outside reset
`define BTKH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btkh check failed");

`endif

// File: rtl/core/btkh_pkg.sv
package btkh_pkg;

    localparam int ID_W   = 24;
    localparam int DIST_W = 32;
    localparam int CNT_W  = 6;
    localparam int RANK_W = 5;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 104;

    localparam logic [DIST_W-1:0] DIST_ALL = '1;
    localparam logic [CNT_W-1:0]  K_RESET  = 6'd8;

    typedef enum logic [1:0] {
        MODE_PUSH    = 2'd0,
        MODE_LOOKUP  = 2'd1,
        MODE_EXTRACT = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_entry;

endpackage

// File: rtl/core/btkh_ram.sv
module btkh_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output btkh_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  btkh_pkg::t_entry  i_wr_data
);

    btkh_pkg::t_entry r_mem [DEPTH];
    btkh_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bounded_topk_nearest_heap_top.sv
// keeps the k nearest candidates (k = neighbor_count) in a max-heap held in a
// single-port-read, single-port-write ram; the root is the worst kept distance.
// input stream: tuser = mode, tdata = candidate id and distance. one request is
// taken only while the block is idle; it then runs to completion.
// output stream: push, look up and clear give one result; extract gives k
// results in ascending distance, the last marked with tlast.
// config channel: neighbor_count is written whenever cfg valid is high; write
// it only while idle and clear the heap afterwards.
// ram reads are registered: an address is given, then its data is used
// from the ram's output register. push and look up scan the held ids one
// entry at a time, then push sifts up or down one level at a time. extract
// does one sift-down per held entry, then emits the results one by one;
// clear goes straight to its result.
// a result waits in the output register while the receiver stalls; the next
// request is taken meanwhile and holds before its own result.
// reset empties the heap and sets neighbor_count to 8; ram contents are not
// cleared and are never read before written.
module bounded_topk_nearest_heap_top #(
    parameter int MAX_NEIGHBORS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // candidate_id [23:0], candidate_distance [55:24]
    input  logic [55:0] i_s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // neighbor_id [23:0], neighbor_distance [55:24], slot_rank [60:56],
    // was_present [61], accepted [62], heap_full [63], worst_distance [95:64],
    // held_count [101:96], zero [103:102]
    output logic [103:0] o_m_axis_tdata,
    // slot_valid [0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    localparam int AW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int KCAP = (MAX_NEIGHBORS < 63) ? MAX_NEIGHBORS : 63;
    localparam logic [btkh_pkg::CNT_W-1:0] KCAP_C = btkh_pkg::CNT_W'(KCAP);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_SU, S_SU_W,
        S_SD_L, S_SD_LW, S_SD_RW, S_SD_MV, S_EX, S_EX_W, S_EM_RD, S_EM_OUT, S_RESP
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_k, n_k;
    logic [5:0] r_total, n_total;
    btkh_pkg::t_mode r_op, n_op;
    btkh_pkg::t_entry r_cand, n_cand, r_cur, n_cur, r_best, n_best, r_root, n_root;
    logic [5:0] r_idx, n_idx, r_n, n_n, r_i, n_i, r_cnt, n_cnt, r_best_idx, n_best_idx;
    logic r_has, n_has, r_present, n_present, r_acc, n_acc;
    logic r_ov, n_ov, r_olast, n_olast, r_ouser, n_ouser;
    logic [103:0] r_odata, n_odata;

    logic w_rd_en, w_wr_en;
    logic [5:0] w_rd_idx, w_wr_idx;
    btkh_pkg::t_entry w_wr_data, w_rd_data;
    logic [5:0] w_k, w_parent;
    logic [6:0] w_left, w_right;
    logic w_out_free, w_full, w_sv;
    logic [31:0] w_worst, w_cmp;
    t_state w_sift_done;

    btkh_ram #(.DEPTH(MAX_NEIGHBORS), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (AW'(w_rd_idx)),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(w_wr_idx)),
        .i_wr_data (w_wr_data)
    );

    always_comb begin
        if (r_k == '0) begin
            w_k = 6'd1;
        end else if (r_k > KCAP_C) begin
            w_k = KCAP_C;
        end else begin
            w_k = r_k;
        end
    end

    assign w_left      = {r_idx, 1'b1};
    assign w_right     = w_left + 7'd1;
    assign w_parent    = 6'(r_idx - 6'd1) >> 1;
    assign w_out_free  = !r_ov || i_m_axis_tready;
    assign w_full      = r_total >= w_k;
    assign w_worst     = (w_full && r_total != '0) ? r_root.distance : btkh_pkg::DIST_ALL;
    assign w_cmp       = r_has ? r_best.distance : r_cur.distance;
    assign w_sv        = r_i < r_cnt;
    assign w_sift_done = (r_op == btkh_pkg::MODE_EXTRACT) ? S_EX : S_RESP;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    always_comb begin
        n_state = r_state;  n_total = r_total;  n_op = r_op;  n_cand = r_cand;
        n_cur = r_cur;  n_best = r_best;  n_idx = r_idx;  n_n = r_n;  n_i = r_i;
        n_cnt = r_cnt;  n_best_idx = r_best_idx;  n_has = r_has;
        n_present = r_present;  n_acc = r_acc;
        n_ov = r_ov;  n_olast = r_olast;  n_ouser = r_ouser;  n_odata = r_odata;
        n_k = i_cfg_valid ? i_cfg_data : r_k;
        w_rd_en = 1'b0;  w_rd_idx = '0;
        w_wr_en = 1'b0;  w_wr_idx = r_idx;  w_wr_data = r_cur;
        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op      = btkh_pkg::t_mode'(i_s_axis_tuser);
                    n_cand    = '{id: i_s_axis_tdata[23:0], distance: i_s_axis_tdata[55:24]};
                    n_present = 1'b0;
                    n_acc     = 1'b0;
                    n_i       = '0;
                    unique case (btkh_pkg::t_mode'(i_s_axis_tuser))
                        btkh_pkg::MODE_PUSH, btkh_pkg::MODE_LOOKUP: n_state = S_SCAN_RD;
                        btkh_pkg::MODE_EXTRACT: begin
                            n_cnt   = (r_total < w_k) ? r_total : w_k;
                            n_n     = (r_total < w_k) ? r_total : w_k;
                            n_state = S_EX;
                        end
                        btkh_pkg::MODE_CLEAR: begin
                            n_total = '0;
                            n_state = S_RESP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_i < r_total) begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = r_i;
                    n_state  = S_SCAN_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_SCAN_CMP: begin
                if (w_rd_data.id == r_cand.id) begin
                    n_present = 1'b1;
                    n_state   = S_DECIDE;
                end else begin
                    n_i     = r_i + 6'd1;
                    n_state = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                if (r_op != btkh_pkg::MODE_PUSH || r_present) begin
                    n_state = S_RESP;
                end else if (r_total < w_k) begin
                    n_cur   = r_cand;
                    n_idx   = r_total;
                    n_total = r_total + 6'd1;
                    n_acc   = 1'b1;
                    n_state = S_SU;
                end else if (r_cand.distance < r_root.distance) begin
                    // replace the root, then sift down over the first k slots
                    n_cur   = r_cand;
                    n_idx   = '0;
                    n_n     = w_k;
                    n_acc   = 1'b1;
                    n_state = S_SD_L;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SU: begin
                if (r_idx == '0) begin
                    w_wr_en = 1'b1;
                    n_state = S_RESP;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_parent;
                    n_state  = S_SU_W;
                end
            end
            S_SU_W: begin
                w_wr_en = 1'b1;
                if (r_cur.distance > w_rd_data.distance) begin
                    // parent moves down into the hole
                    w_wr_data = w_rd_data;
                    n_idx     = w_parent;
                    n_state   = S_SU;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SD_L: begin
                n_has = 1'b0;
                if (w_left < {1'b0, r_n}) begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_left[5:0];
                    n_state  = S_SD_LW;
                end else begin
                    w_wr_en = 1'b1;
                    n_state = w_sift_done;
                end
            end
            S_SD_LW: begin
                if (w_rd_data.distance > r_cur.distance) begin
                    n_best     = w_rd_data;
                    n_best_idx = w_left[5:0];
                    n_has      = 1'b1;
                end
                if (w_right < {1'b0, r_n}) begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_right[5:0];
                    n_state  = S_SD_RW;
                end else begin
                    n_state = S_SD_MV;
                end
            end
            S_SD_RW: begin
                if (w_rd_data.distance > w_cmp) begin
                    n_best     = w_rd_data;
                    n_best_idx = w_right[5:0];
                    n_has      = 1'b1;
                end
                n_state = S_SD_MV;
            end
            S_SD_MV: begin
                w_wr_en = 1'b1;
                if (r_has) begin
                    w_wr_data = r_best;
                    n_idx     = r_best_idx;
                    n_state   = S_SD_L;
                end else begin
                    n_state = w_sift_done;
                end
            end
            S_EX: begin
                if (r_n == '0) begin
                    n_total = '0;
                    n_i     = '0;
                    n_state = S_EM_RD;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = r_n - 6'd1;
                    n_n      = r_n - 6'd1;
                    n_state  = S_EX_W;
                end
            end
            S_EX_W: begin
                // root goes to the tail slot, tail entry sifts down from the top
                w_wr_en   = 1'b1;
                w_wr_idx  = r_n;
                w_wr_data = r_root;
                n_cur     = w_rd_data;
                n_idx     = '0;
                n_state   = (r_n == '0) ? S_EX : S_SD_L;
            end
            S_EM_RD: begin
                if (w_sv) begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = r_i;
                end
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_ouser = w_sv;
                    n_olast = (r_i == w_k - 6'd1);
                    n_odata = {2'b00, r_total, w_worst, w_full, 1'b0, 1'b0, r_i[4:0],
                               w_sv ? w_rd_data.distance : btkh_pkg::DIST_ALL,
                               w_sv ? w_rd_data.id : 24'd0};
                    n_i     = r_i + 6'd1;
                    n_state = (r_i == w_k - 6'd1) ? S_IDLE : S_EM_RD;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_ouser = 1'b0;
                    n_olast = 1'b1;
                    n_odata = {2'b00, r_total, w_worst, w_full, r_acc, r_present, 5'd0,
                               btkh_pkg::DIST_ALL, 24'd0};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_root = (w_wr_en && w_wr_idx == '0) ? w_wr_data : r_root;
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_cand <= n_cand;  r_cur <= n_cur;  r_best <= n_best;
        r_root <= n_root;  r_idx <= n_idx;  r_n <= n_n;  r_i <= n_i;  r_cnt <= n_cnt;
        r_best_idx <= n_best_idx;  r_has <= n_has;  r_present <= n_present;
        r_acc <= n_acc;  r_olast <= n_olast;  r_ouser <= n_ouser;  r_odata <= n_odata;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= btkh_pkg::K_RESET;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
    end

endmodule

// File: rtl/core/btkh_checker.sv
`include "bounded_topk_nearest_heap_top_assert.svh"

module btkh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [55:0]  i_s_axis_tdata,
    input logic [1:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [103:0] o_m_axis_tdata,
    input logic         o_m_axis_tuser,
    input logic         o_m_axis_tlast,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [5:0]   i_cfg_data
);

    // a stalled result keeps its contents
    `BTKH_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // padding and status results carry id zero and distance all-ones
    `BTKH_ASSERT_NOW(a_pad_fields, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[23:0] == 24'd0 && o_m_axis_tdata[55:24] == 32'hFFFF_FFFF)

    // worst distance is the sentinel unless the heap is full
    `BTKH_ASSERT_NOW(a_worst_sentinel, o_m_axis_tvalid && !o_m_axis_tdata[63], o_m_axis_tdata[95:64] == 32'hFFFF_FFFF)

    // extracted slots report an emptied heap with no push flags
    `BTKH_ASSERT_NOW(a_extract_empty, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[101:96] == 6'd0 && o_m_axis_tdata[62:61] == 2'b00)

endmodule

bind bounded_topk_nearest_heap_top btkh_checker u_btkh_checker (.*);
